// File: hw/rtl/clkv_pkg.sv
// clkv_pkg: shared types and constants for the command line key/value scanner.
// No dependencies; imported by clkv_cfg_regs, clkv_scan_core and the top level.
package clkv_pkg;

    // Register interface
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 64;
    localparam int REG_SEL_BIT  = 3;
    localparam int KEY_LEN_W    = 4;

    typedef enum logic
    {
        REG_KEY_BYTES  = 1'b0,
        REG_KEY_LENGTH = 1'b1
    } reg_sel_t;

    // Character codes
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;

    // One scan step's result, from the core to the output register
    typedef struct packed
    {
        logic       has_result;
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       value_end;
        logic       bare_match;
        logic       scan_final;
        logic       key_found;
    } scan_result_t;

endpackage

// File: hw/rtl/command_line_key_value_scanner.sv
// command_line_key_value_scanner: top level with input and result registers.
// Depends on clkv_pkg, clkv_cfg_regs and clkv_scan_core.
//
// Scans a command line one byte per transfer for the key held in key_bytes /
// key_length (APB offsets 0x0 and 0x8, 64-bit data). Bytes of the first
// matching token's value stream out as they arrive; a bare token equal to the
// key gives bare_match; the transfer for the byte marked line_last carries
// scan_final and key_found. Bytes that give no result produce no output
// transfer. The block takes one byte per cycle while no held result stalls it:
// each byte waits in the input register, the scan step updates the tokenizer
// state as the byte moves on, and its result lands in the output register. A
// result held by out_ready low stalls the input only when the byte behind it
// also has a result. Write the registers only while the block is idle.
module command_line_key_value_scanner #(
    parameter int KEY_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clkv_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [clkv_pkg::APB_DATA_W-1:0] pwdata,
    output logic [clkv_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // line byte input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      line_byte,
    input  logic                            line_last,
    // result output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      value_byte,
    output logic                            byte_valid,
    output logic                            value_end,
    output logic                            bare_match,
    output logic                            scan_final,
    output logic                            key_found
);
    import clkv_pkg::*;

    logic [KEY_BYTES*8-1:0] key_bytes;
    logic [KEY_LEN_W-1:0]   key_length;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         advance;
    logic         out_valid_reg;
    scan_result_t res;
    scan_result_t res_reg;

    clkv_cfg_regs #(
        .KEY_BYTES (KEY_BYTES)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .key_bytes  (key_bytes),
        .key_length (key_length)
    );

    clkv_scan_core #(
        .KEY_BYTES (KEY_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .line_byte  (in_byte_reg),
        .line_last  (in_last_reg),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .result     (res)
    );

    // Held byte moves on unless its result has nowhere to go
    assign advance  = in_valid_reg && (!res.has_result || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= line_byte;
            in_last_reg <= line_last;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.has_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.has_result)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign value_byte = res_reg.value_byte;
    assign byte_valid = res_reg.byte_valid;
    assign value_end  = res_reg.value_end;
    assign bare_match = res_reg.bare_match;
    assign scan_final = res_reg.scan_final;
    assign key_found  = res_reg.key_found;

`ifndef NO_ASSERTIONS
    // every output transfer carries at least one event
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || value_end || bare_match || scan_final))
        else $error("empty result transfer");

    // key_found only accompanies the end of a line
    a_found_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_found) |-> scan_final)
        else $error("key_found without scan_final");

    // a bare match never shares a transfer with value data
    a_bare_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bare_match) |-> (!byte_valid && !value_end))
        else $error("bare_match mixed with value output");

    // an empty input register always takes the next byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");
`endif

endmodule

// File: hw/rtl/clkv_cfg_regs.sv
// clkv_cfg_regs: APB register file holding the searched key and its length.
// Depends on clkv_pkg.
module clkv_cfg_regs #(
    parameter int KEY_BYTES = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [clkv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [clkv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [clkv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [KEY_BYTES*8-1:0]             key_bytes,
    output logic [clkv_pkg::KEY_LEN_W-1:0]     key_length
);
    import clkv_pkg::*;

    logic [KEY_BYTES*8-1:0] key_bytes_reg;
    logic [KEY_LEN_W-1:0]   key_length_reg;
    logic                   wr_en;
    reg_sel_t               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_sel_t'(paddr[REG_SEL_BIT]);

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg  <= '0;
            key_length_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_KEY_BYTES:  key_bytes_reg  <= pwdata[KEY_BYTES*8-1:0];
                REG_KEY_LENGTH: key_length_reg <= pwdata[KEY_LEN_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_KEY_BYTES:  prdata = APB_DATA_W'(key_bytes_reg);
            REG_KEY_LENGTH: prdata = APB_DATA_W'(key_length_reg);
        endcase
    end

    assign key_bytes  = key_bytes_reg;
    assign key_length = key_length_reg;

endmodule

// File: hw/rtl/clkv_scan_core.sv
// clkv_scan_core: tokenizer state and the single-byte scan step.
// Depends on clkv_pkg; fed from the top level's input register.
module clkv_scan_core #(
    parameter int KEY_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [7:0]                      line_byte,
    input  logic                            line_last,
    input  logic [KEY_BYTES*8-1:0]          key_bytes,
    input  logic [clkv_pkg::KEY_LEN_W-1:0]  key_length,
    output clkv_pkg::scan_result_t          result
);
    import clkv_pkg::*;

    typedef enum logic [1:0]
    {
        PH_SKIP,
        PH_PLAIN,
        PH_QUOTED,
        PH_DONE
    } phase_t;

    localparam logic [KEY_LEN_W-1:0] KEY_MAX = KEY_LEN_W'(KEY_BYTES);

    phase_t               phase_reg, phase_next;
    logic [KEY_LEN_W-1:0] pos_reg, pos_next;
    logic                 still_reg, still_next;
    logic                 eq_reg, eq_next;
    logic                 qcs_reg, qcs_next;
    logic                 esc_reg, esc_next;
    logic                 emit_reg, emit_next;
    logic                 match_reg, match_next;

    logic [KEY_LEN_W-1:0] klen;
    logic [7:0]           key_sel;
    logic                 is_ws, is_quote, is_eq, is_bs;
    logic                 content, end_now, end_req;

    assign klen     = (key_length > KEY_MAX) ? KEY_MAX : key_length;
    assign is_ws    = (line_byte == CHAR_SPACE) || (line_byte == CHAR_TAB);
    assign is_quote = (line_byte == CHAR_QUOTE);
    assign is_eq    = (line_byte == CHAR_EQUALS);
    assign is_bs    = (line_byte == CHAR_BACKSLASH);

    // Scan step: token start, content byte, token end, line end
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        still_next = still_reg;
        eq_next    = eq_reg;
        qcs_next   = qcs_reg;
        esc_next   = esc_reg;
        emit_next  = emit_reg;
        match_next = match_reg;
        content    = 1'b0;
        end_now    = 1'b0;
        key_sel    = '0;
        end_req    = 1'b0;
        result     = '0;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (!is_ws)
                begin
                    phase_next = is_quote ? PH_QUOTED : PH_PLAIN;
                    pos_next   = '0;
                    still_next = 1'b1;
                    eq_next    = 1'b0;
                    qcs_next   = 1'b0;
                    esc_next   = 1'b0;
                    content    = !is_quote;
                end
            end
            PH_PLAIN:
            begin
                if (is_ws)
                    end_now = 1'b1;
                else
                    content = 1'b1;
            end
            PH_QUOTED:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    content  = 1'b1;
                end
                else if (is_quote)
                begin
                    // empty quoted token halts the scan
                    if (!qcs_reg)
                        phase_next = PH_DONE;
                    else
                        end_now = 1'b1;
                end
                else
                begin
                    if (is_bs)
                        esc_next = 1'b1;
                    content = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
        endcase

        // key byte at the current compare position
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (pos_next == KEY_LEN_W'(i))
                key_sel = key_bytes[i*8 +: 8];
        end

        // content byte handling
        if (content)
        begin
            qcs_next = 1'b1;
            if (emit_next)
            begin
                result.value_byte = line_byte;
                result.byte_valid = 1'b1;
            end
            else if (!eq_next)
            begin
                if (is_eq)
                begin
                    eq_next = 1'b1;
                    if (still_next && (pos_next == klen))
                    begin
                        match_next = 1'b1;
                        emit_next  = 1'b1;
                    end
                end
                else if (still_next && (pos_next < klen) && (key_sel == line_byte))
                    pos_next = pos_next + 1'b1;
                else
                    still_next = 1'b0;
            end
        end

        // line end closes an open token, or halts on a bare opening quote
        if (line_last && (phase_next == PH_QUOTED) && !qcs_next)
            phase_next = PH_DONE;
        else if (line_last && ((phase_next == PH_PLAIN) || (phase_next == PH_QUOTED)))
            end_req = 1'b1;
        end_req = end_req || end_now;

        // token end
        if (end_req)
        begin
            if (emit_next)
            begin
                result.value_end = 1'b1;
                emit_next        = 1'b0;
                phase_next       = PH_DONE;
            end
            else if (!eq_next && still_next && (pos_next == klen))
            begin
                result.bare_match = 1'b1;
                match_next        = 1'b1;
                phase_next        = PH_DONE;
            end
            else
                phase_next = PH_SKIP;
        end

        result.scan_final = line_last;
        result.key_found  = line_last && match_next;
        result.has_result = result.byte_valid || result.value_end ||
                            result.bare_match || line_last;

        // new command line starts from the reset state
        if (line_last)
        begin
            phase_next = PH_SKIP;
            pos_next   = '0;
            still_next = 1'b1;
            eq_next    = 1'b0;
            qcs_next   = 1'b0;
            esc_next   = 1'b0;
            emit_next  = 1'b0;
            match_next = 1'b0;
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            pos_reg   <= '0;
            still_reg <= 1'b1;
            eq_reg    <= 1'b0;
            qcs_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            emit_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            still_reg <= still_next;
            eq_reg    <= eq_next;
            qcs_reg   <= qcs_next;
            esc_reg   <= esc_next;
            emit_reg  <= emit_next;
            match_reg <= match_next;
        end
    end

endmodule
